// File: hdl/mhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Field widths, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W        = 32;
    localparam int OPCODE_W     = 3;
    localparam int INDEX_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 8;
    localparam int CAPACITY_DEF = 128;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_EXTRACT = 3'd1,
        OP_CHANGE  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_PEEK    = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // Heap position loaded when an item is taken
    typedef enum logic [1:0] {
        POS_ROOT  = 2'd0,
        POS_INDEX = 2'd1,
        POS_COUNT = 2'd2
    } pos_sel_t;

    // Store read addresses
    typedef enum logic [1:0] {
        RD_FETCH  = 2'd0,
        RD_PARENT = 2'd1,
        RD_CHILD  = 2'd2
    } rd_sel_t;

    // Store write source; every write goes to the current hole
    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_KEY    = 2'd1,
        WR_PARENT = 2'd2,
        WR_CHILD  = 2'd3
    } wr_sel_t;

    typedef struct packed {
        logic     load_in;
        pos_sel_t pos_sel;
        logic     count_inc;
        logic     count_dec;
        logic     take_value;
        logic     take_last;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        status_t in_status;
        logic    pos_root;
        logic    pos_is_last;
        logic    parent_less;
        logic    down_stop;
    } stat_t;

endpackage
`default_nettype wire

// File: hdl/mhpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram: generic RAM, one write port and two registered read ports
// Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

// File: hdl/mhpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ctrl: operation sequencer of the heap
// Steps each item through the fetch, sift up and sift down steps that its
// operation needs, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [mhpq_pkg::OPCODE_W-1:0]   opcode,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    input  wire mhpq_pkg::stat_t                 st,
    output mhpq_pkg::cmd_t                       cmd
);

    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_TAKE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t  state_reg, state_next;
    opcode_t op_reg, op_next;
    logic    do_down_reg, do_down_next;
    logic    out_valid_reg, out_valid_next;
    opcode_t op_in;

    assign op_in     = opcode_t'(opcode);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        op_next      = op_reg;
        do_down_next = do_down_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = op_in;
                    unique case (op_in)
                        OP_INSERT:             cmd.pos_sel = POS_COUNT;
                        OP_CHANGE, OP_DELETE:  cmd.pos_sel = POS_INDEX;
                        default:               cmd.pos_sel = POS_ROOT;
                    endcase
                    if (st.in_status != ST_OK)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        unique case (op_in)
                            OP_INSERT:
                            begin
                                cmd.count_inc = 1'b1;
                                do_down_next  = 1'b0;
                                state_next    = S_UP_RD;
                            end
                            OP_EXTRACT, OP_CHANGE, OP_DELETE, OP_PEEK:
                            begin
                                state_next = S_FETCH;
                            end
                            default:
                            begin
                                state_next = S_FINISH;
                            end
                        endcase
                    end
                end
            end
            S_FETCH:
            begin
                cmd.rd_sel = RD_FETCH;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take_value = 1'b1;
                unique case (op_reg)
                    OP_EXTRACT:
                    begin
                        cmd.take_last = 1'b1;
                        cmd.count_dec = 1'b1;
                        state_next    = S_DN_RD;
                    end
                    OP_DELETE:
                    begin
                        cmd.take_last = 1'b1;
                        cmd.count_dec = 1'b1;
                        do_down_next  = 1'b1;
                        state_next    = st.pos_is_last ? S_FINISH : S_UP_RD;
                    end
                    OP_CHANGE:
                    begin
                        do_down_next = 1'b1;
                        state_next   = S_UP_RD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_UP_RD:
            begin
                if (!st.pos_root)
                begin
                    cmd.rd_sel = RD_PARENT;
                    state_next = S_UP_CMP;
                end
                else if (do_down_reg)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                    state_next = S_FINISH;
                end
            end
            S_UP_CMP:
            begin
                if (st.parent_less)
                begin
                    cmd.wr_sel = WR_PARENT;
                    state_next = S_UP_RD;
                end
                else if (do_down_reg)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                    state_next = S_FINISH;
                end
            end
            S_DN_RD:
            begin
                cmd.rd_sel = RD_CHILD;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (st.down_stop)
                begin
                    cmd.wr_sel = WR_KEY;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.wr_sel = WR_CHILD;
                    state_next = S_DN_RD;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_INSERT;
            do_down_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            do_down_reg   <= do_down_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && out_valid_reg && !out_ready |=> state_reg == S_FINISH)
        else $error("finished item left while the output register was still full");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result presented outside the finish step");

    a_sift_up_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_RD || state_reg == S_UP_CMP) |->
        (op_reg == OP_INSERT || op_reg == OP_CHANGE || op_reg == OP_DELETE))
        else $error("sift up entered for an operation that never sifts up");
`endif

endmodule
`default_nettype wire

// File: hdl/mhpq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_dpath: heap store, hole position, moving key, count and result regs
// Moves a hole through the store one level per step; the moving key is
// held in a register and written once the hole settles.
// ----------------------------------------------------------------------------
module mhpq_dpath #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [mhpq_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]   key,
    input  wire logic [mhpq_pkg::INDEX_W-1:0]        index,
    input  wire mhpq_pkg::cmd_t                      cmd,
    output mhpq_pkg::stat_t                          st,
    output logic signed [mhpq_pkg::KEY_W-1:0]        value,
    output logic [mhpq_pkg::STATUS_W-1:0]            status,
    output logic [mhpq_pkg::COUNT_W-1:0]             count
);

    import mhpq_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CHW  = AW + 2;
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] value_reg, value_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           count_reg, count_next;
    status_t                 status_reg, status_next;
    logic signed [KEY_W-1:0] out_value_reg;
    status_t                 out_status_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic signed [KEY_W-1:0] rd_a, rd_b;
    logic [KEY_W-1:0]        ram_rdata_a, ram_rdata_b;
    logic [AW-1:0]           raddr_a, raddr_b;
    logic                    ram_we;
    logic [KEY_W-1:0]        ram_wdata;

    logic [AW-1:0]           pos_m1, parent;
    logic [CW-1:0]           last_w;
    logic [CHW-1:0]          left_w, right_w, cnt_w;
    logic                    left_ok, right_ok, take_l, take_r;
    logic [AW-1:0]           big_addr;
    logic signed [KEY_W-1:0] big_data;
    status_t                 in_status;
    opcode_t                 op_in;

    assign rd_a = ram_rdata_a;
    assign rd_b = ram_rdata_b;

    assign pos_m1   = pos_reg - AW'(1);
    assign parent   = pos_m1 >> 1;
    assign last_w   = count_reg - CW'(1);
    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = left_w + CHW'(1);
    assign cnt_w    = CHW'(count_reg);
    assign left_ok  = left_w < cnt_w;
    assign right_ok = right_w < cnt_w;

    // Pick the larger child; ties keep the left one or the moving key
    always_comb
    begin
        take_l = left_ok && (key_reg < rd_a);
        if (take_l)
        begin
            take_r = right_ok && (rd_a < rd_b);
        end
        else
        begin
            take_r = right_ok && (key_reg < rd_b);
        end
    end

    assign big_addr = take_r ? right_w[AW-1:0] : left_w[AW-1:0];
    assign big_data = take_r ? rd_b : rd_a;

    assign op_in = opcode_t'(opcode);

    always_comb
    begin
        unique case (op_in)
            OP_INSERT:
                in_status = (count_reg == CW'(CAPACITY)) ? ST_FULL : ST_OK;
            OP_EXTRACT, OP_PEEK:
                in_status = (count_reg == '0) ? ST_EMPTY : ST_OK;
            OP_CHANGE, OP_DELETE:
                in_status = (CMPW'(index) >= CMPW'(count_reg)) ? ST_BADIDX : ST_OK;
            default:
                in_status = ST_OK;
        endcase
    end

    assign st.in_status   = in_status;
    assign st.pos_root    = (pos_reg == '0);
    assign st.pos_is_last = (CW'(pos_reg) == last_w);
    assign st.parent_less = (rd_a < key_reg);
    assign st.down_stop   = !take_l && !take_r;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_PARENT: raddr_a = parent;
            RD_CHILD:  raddr_a = left_w[AW-1:0];
            default:   raddr_a = pos_reg;
        endcase
        raddr_b = (cmd.rd_sel == RD_CHILD) ? right_w[AW-1:0] : last_w[AW-1:0];
    end

    assign ram_we = (cmd.wr_sel != WR_NONE);

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_PARENT: ram_wdata = rd_a;
            WR_CHILD:  ram_wdata = big_data;
            default:   ram_wdata = key_reg;
        endcase
    end

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (pos_reg),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    always_comb
    begin
        key_next    = key_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        status_next = status_reg;

        if (cmd.load_in)
        begin
            key_next    = key;
            value_next  = '0;
            status_next = in_status;
            unique case (cmd.pos_sel)
                POS_INDEX: pos_next = AW'(index);
                POS_COUNT: pos_next = AW'(count_reg);
                default:   pos_next = '0;
            endcase
        end
        if (cmd.take_value)
        begin
            value_next = rd_a;
        end
        if (cmd.take_last)
        begin
            key_next = rd_b;
        end
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = last_w;
        end
        if (cmd.wr_sel == WR_PARENT)
        begin
            pos_next = parent;
        end
        else if (cmd.wr_sel == WR_CHILD)
        begin
            pos_next = big_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        if (cmd.out_load)
        begin
            out_value_reg  <= value_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign value  = out_value_reg;
    assign status = out_status_reg;
    assign count  = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_dec |-> count_reg != '0)
        else $error("entry removed from an empty heap");

    a_child_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_sel == WR_CHILD |-> (take_r ? right_w : left_w) < cnt_w)
        else $error("hole moved to a child outside the heap");
`endif

endmodule
`default_nettype wire

// File: hdl/max_heap_priority_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core: binary max-heap of signed 32-bit keys
// Insert, extract max, change key, delete at index and peek max, one
// result per item.
// ----------------------------------------------------------------------------
// One item at a time: in_ready is high only while the sequencer is idle, and
// the result sits in an output register, so the next item may be taken while
// the previous result still waits. Each item passes through an accept step,
// a fetch and a take step for operations that read the store, a read of the
// parent or both children and then a compare that moves the hole for each
// heap level walked by a sift, the closing read and compare that stops each
// sift (at the root on the way up, a single check without a read), and a
// step that loads the result; an error or a spare opcode goes straight from
// accept to the result load, and a finished item may wait for the output
// register. The single-write, dual-read store sets the pace: one level per
// read-compare-write round trip. The store needs no clearing after reset;
// only data from positions below the entry count is used.
// The count port reports the entry count modulo 256.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // item in
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [mhpq_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic signed [mhpq_pkg::KEY_W-1:0]   key,
    input  wire logic [mhpq_pkg::INDEX_W-1:0]        index,
    // result out
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [mhpq_pkg::KEY_W-1:0]        value,
    output logic [mhpq_pkg::STATUS_W-1:0]            status,
    output logic [mhpq_pkg::COUNT_W-1:0]             count
);

    import mhpq_pkg::*;

    // Commands from the sequencer, flags back from the datapath
    cmd_t  cmd;
    stat_t st;

    // Sequence each item: decide the path at accept, walk the sift loops,
    // hold the finished item until the output register is free.
    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Hold the store, the moving key and hole position, the count, and the
    // result registers that drive the output payload.
    mhpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .opcode (opcode),
        .key    (key),
        .index  (index),
        .cmd    (cmd),
        .st     (st),
        .value  (value),
        .status (status),
        .count  (count)
    );

endmodule
`default_nettype wire
